// ----- rtl/smvg_pkg.sv -----
// Shared constants, types and helper functions of the sphere mesh vertex generator.
package smvg_pkg;

    // Grid and angle resolution
    localparam int SEGMENT_BITS = 8;
    localparam int ANGLE_BITS   = 16;
    localparam int ANG_SHIFT    = 32 - ANGLE_BITS;

    // Long division: product of a grid index and a 17-bit sweep, scaled by 2^16
    localparam int DIV_W = SEGMENT_BITS + 17 + 16;

    // CORDIC
    localparam int COR_STEPS = 24;
    localparam int COR_W     = 34;
    localparam int COR_LAT   = COR_STEPS + 2;
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] ATAN_TURN [COR_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Front pipeline: input, divider, angle, CORDIC, four multiply/round stages
    localparam int NSTG = 1 + DIV_W + 1 + COR_LAT + 4;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Register indexes
    localparam logic [2:0] REG_RADIUS       = 3'd0;
    localparam logic [2:0] REG_WIDTH_SEGS   = 3'd1;
    localparam logic [2:0] REG_HEIGHT_SEGS  = 3'd2;
    localparam logic [2:0] REG_PHI_START    = 3'd3;
    localparam logic [2:0] REG_PHI_LENGTH   = 3'd4;
    localparam logic [2:0] REG_THETA_START  = 3'd5;
    localparam logic [2:0] REG_THETA_LENGTH = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [15:0]             radius;
        logic [SEGMENT_BITS-1:0] seg_around;
        logic [SEGMENT_BITS-1:0] seg_rings;
        logic [15:0]             phi_start;
        logic [16:0]             phi_length;
        logic [15:0]             theta_start;
        logic [15:0]             theta_length;
    } cfg_t;

    typedef struct packed {
        logic [SEGMENT_BITS-1:0] row;
        logic [SEGMENT_BITS-1:0] col;
        logic [SEGMENT_BITS-1:0] w;
        logic                    outside;
        logic                    tri_a;
        logic                    tri_b;
        logic                    u_neg;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [15:0] tu;
        logic [14:0] tv;
    } side2_t;

    typedef struct packed {
        logic               outside;
        logic               tri_a;
        logic               tri_b;
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] pz;
        logic [15:0]        tu;
        logic [14:0]        tv;
        logic [15:0]        ia;
        logic [15:0]        ib;
        logic [15:0]        ic;
        logic [15:0]        id;
    } qitem_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] tex_u;
        logic [14:0] tex_v;
        logic [15:0] index_a;
        logic [15:0] index_b;
        logic [15:0] index_c;
        logic        last;
    } res_t;

    // Clamp a position to the symmetric Q8.8 range
    function automatic logic signed [16:0] sat_pos(input logic signed [21:0] v);
        logic signed [16:0] r;
        if (v > 22'sd65535)
            r = 17'sd65535;
        else if (v < -22'sd65535)
            r = -17'sd65535;
        else
            r = v[16:0];
        return r;
    endfunction

endpackage

// ----- rtl/smvg_if.sv -----
// Handshake interfaces: request, result and configuration write channels.
interface smvg_req_if
    import smvg_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [SEGMENT_BITS-1:0] row;
    logic [SEGMENT_BITS-1:0] col;
    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

interface smvg_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] tex_u;
    logic [14:0] tex_v;
    logic [15:0] index_a;
    logic [15:0] index_b;
    logic [15:0] index_c;
    logic        last;
    modport source (output valid, output kind, output pos_x, output pos_y, output pos_z,
                    output tex_u, output tex_v, output index_a, output index_b,
                    output index_c, output last, input ready);
    modport sink   (input valid, input kind, input pos_x, input pos_y, input pos_z,
                    input tex_u, input tex_v, input index_a, input index_b,
                    input index_c, input last, output ready);
endinterface

interface smvg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [16:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/smvg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module smvg_div
    import smvg_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [DIV_W-1:0]        dvd,
    input  logic [SEGMENT_BITS-1:0] dvs,
    output logic [DIV_W-1:0]        quo
);

    logic [SEGMENT_BITS-1:0] rem_reg  [DIV_W];
    logic [DIV_W-1:0]        rest_reg [DIV_W];
    logic [SEGMENT_BITS-1:0] dvs_reg  [DIV_W];

    genvar k;
    generate
        for (k = 0; k < DIV_W; k++)
        begin : g_step
            logic [SEGMENT_BITS-1:0] rem_in;
            logic [SEGMENT_BITS-1:0] dvs_in;
            logic [DIV_W-1:0]        rest_in;
            logic [SEGMENT_BITS:0]   trial;
            logic [SEGMENT_BITS:0]   diff;
            logic                    ge;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign rest_in = dvd;
                assign dvs_in  = dvs;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign rest_in = rest_reg[k-1];
                assign dvs_in  = dvs_reg[k-1];
            end

            // shift in the next dividend bit, subtract when it fits
            assign trial = {rem_in, rest_in[DIV_W-1]};
            assign diff  = trial - {1'b0, dvs_in};
            assign ge    = (trial >= {1'b0, dvs_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? diff[SEGMENT_BITS-1:0] : trial[SEGMENT_BITS-1:0];
                    rest_reg[k] <= {rest_in[DIV_W-2:0], ge};
                    dvs_reg[k]  <= dvs_in;
                end
            end
        end
    endgenerate

    assign quo = rest_reg[DIV_W-1];

endmodule

// ----- rtl/smvg_cordic.sv -----
// Pipelined CORDIC rotation giving Q2.30 cosine and sine of a turn-fraction angle.
module smvg_cordic
    import smvg_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        ang,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q
);

    logic signed [COR_W-1:0] x_reg [COR_STEPS+1];
    logic signed [COR_W-1:0] y_reg [COR_STEPS+1];
    logic signed [COR_W-1:0] z_reg [COR_STEPS+1];
    logic                    neg_reg [COR_STEPS+1];

    logic        neg;
    logic [31:0] ang_f;
    logic signed [COR_W-1:0] xn;
    logic signed [COR_W-1:0] yn;

    // fold the left half plane onto the right one
    assign neg   = ang[31] ^ ang[30];
    assign ang_f = {ang[31] ^ neg, ang[30:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= $signed({{(COR_W-32){1'b0}}, GAIN_Q30});
            y_reg[0]   <= '0;
            z_reg[0]   <= $signed({{(COR_W-32){ang_f[31]}}, ang_f});
            neg_reg[0] <= neg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < COR_STEPS; i++)
        begin : g_iter
            logic signed [COR_W-1:0] dx;
            logic signed [COR_W-1:0] dy;
            logic signed [COR_W-1:0] at;

            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;
            assign at = $signed({{(COR_W-32){1'b0}}, ATAN_TURN[i]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!z_reg[i][COR_W-1])
                    begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        z_reg[i+1] <= z_reg[i] - at;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        z_reg[i+1] <= z_reg[i] + at;
                    end
                    neg_reg[i+1] <= neg_reg[i];
                end
            end
        end
    endgenerate

    // undo the fold
    assign xn = neg_reg[COR_STEPS] ? -x_reg[COR_STEPS] : x_reg[COR_STEPS];
    assign yn = neg_reg[COR_STEPS] ? -y_reg[COR_STEPS] : y_reg[COR_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_q <= xn[31:0];
            sin_q <= yn[31:0];
        end
    end

endmodule

// ----- rtl/smvg_front.sv -----
// Front pipeline: accepts requests, classifies them and computes vertex data.
module smvg_front
    import smvg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    smvg_req_if.sink   req,
    input  cfg_t       cfg,
    output qitem_t     q_item,
    output logic       q_push,
    input  logic       q_full
);

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    // Whole pipeline moves together; it holds only when the last stage is blocked
    assign adv       = !vld_reg[NSTG-1] || !q_full;
    assign req.ready = adv;
    assign q_push    = adv && vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], req.valid};
    end

    // Input stage
    logic [SEGMENT_BITS-1:0] row0_reg;
    logic [SEGMENT_BITS-1:0] col0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row0_reg <= req.row;
            col0_reg <= req.col;
        end
    end

    // Classification and dividends
    logic [SEGMENT_BITS-1:0] w;
    logic [SEGMENT_BITS-1:0] h;
    logic [SEGMENT_BITS-1:0] h_row;
    logic [16:0]             sweep_end;
    logic                    reaches_bottom;
    logic                    in_cell;
    logic                    top_pole;
    logic                    bot_pole;
    logic [22:0]             col_sc;
    logic [22:0]             u_mag;
    logic [24:0]             phi_prod;
    logic [23:0]             theta_prod;
    logic [DIV_W-1:0]        dvd_phi;
    logic [DIV_W-1:0]        dvd_theta;
    logic [DIV_W-1:0]        dvd_u;
    logic [DIV_W-1:0]        dvd_v;
    side_t                   side0;

    assign w = (cfg.seg_around < SEGMENT_BITS'(3)) ? SEGMENT_BITS'(3) : cfg.seg_around;
    assign h = (cfg.seg_rings < SEGMENT_BITS'(2)) ? SEGMENT_BITS'(2) : cfg.seg_rings;
    assign h_row          = h - row0_reg;
    assign sweep_end      = {1'b0, cfg.theta_start} + {1'b0, cfg.theta_length};
    assign reaches_bottom = (sweep_end >= 17'd32768);
    assign in_cell        = (row0_reg < h) && (col0_reg < w);
    assign top_pole       = (row0_reg == '0) && (cfg.theta_start == '0);
    assign bot_pole       = (row0_reg == h) && reaches_bottom;
    assign col_sc         = {1'b0, col0_reg, 14'b0};

    always_comb
    begin
        if (top_pole)
            u_mag = col_sc + 23'd8192;
        else if (bot_pole && col0_reg == '0)
            u_mag = 23'd8192;
        else if (bot_pole)
            u_mag = col_sc - 23'd8192;
        else
            u_mag = col_sc;
    end

    assign phi_prod   = {17'b0, col0_reg} * {8'b0, cfg.phi_length};
    assign theta_prod = {16'b0, row0_reg} * {8'b0, cfg.theta_length};
    assign dvd_phi    = {phi_prod, 16'b0};
    assign dvd_theta  = {1'b0, theta_prod, 16'b0};
    assign dvd_u      = DIV_W'(u_mag) + DIV_W'(w >> 1);
    assign dvd_v      = DIV_W'({h_row, 14'b0}) + DIV_W'(h >> 1);

    assign side0.row     = row0_reg;
    assign side0.col     = col0_reg;
    assign side0.w       = w;
    assign side0.outside = (row0_reg > h) || (col0_reg > w);
    assign side0.tri_a   = in_cell && ((row0_reg != '0) || (cfg.theta_start != '0));
    assign side0.tri_b   = in_cell && ((row0_reg != h - SEGMENT_BITS'(1)) || !reaches_bottom);
    assign side0.u_neg   = !top_pole && bot_pole && (col0_reg == '0);

    // Dividers
    logic [DIV_W-1:0] q_phi;
    logic [DIV_W-1:0] q_theta;
    logic [DIV_W-1:0] q_u;
    logic [DIV_W-1:0] q_v;

    smvg_div u_div_phi   (.clk(clk), .en(adv), .dvd(dvd_phi),   .dvs(w), .quo(q_phi));
    smvg_div u_div_theta (.clk(clk), .en(adv), .dvd(dvd_theta), .dvs(h), .quo(q_theta));
    smvg_div u_div_u     (.clk(clk), .en(adv), .dvd(dvd_u),     .dvs(w), .quo(q_u));
    smvg_div u_div_v     (.clk(clk), .en(adv), .dvd(dvd_v),     .dvs(h), .quo(q_v));

    side_t side_d_reg [DIV_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_d_reg[0] <= side0;
            for (int k = 1; k < DIV_W; k++)
                side_d_reg[k] <= side_d_reg[k-1];
        end
    end

    // Angle stage: add start angles, finish texture coordinates
    logic [31:0] ang_phi_reg;
    logic [31:0] ang_theta_reg;
    side2_t      sa_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_phi_reg    <= {cfg.phi_start, 16'b0} + q_phi[31:0];
            ang_theta_reg  <= {cfg.theta_start, 16'b0} + q_theta[31:0];
            sa_reg.side    <= side_d_reg[DIV_W-1];
            sa_reg.tu      <= side_d_reg[DIV_W-1].u_neg ? 16'(-q_u[15:0]) : q_u[15:0];
            sa_reg.tv      <= q_v[14:0];
        end
    end

    // Round angles to ANGLE_BITS of a turn
    logic [32:0] rnd_phi;
    logic [32:0] rnd_theta;
    logic [31:0] cin_phi;
    logic [31:0] cin_theta;

    assign rnd_phi   = {1'b0, ang_phi_reg} + (33'd1 << (ANG_SHIFT - 1));
    assign rnd_theta = {1'b0, ang_theta_reg} + (33'd1 << (ANG_SHIFT - 1));
    assign cin_phi   = {rnd_phi[31:ANG_SHIFT], {ANG_SHIFT{1'b0}}};
    assign cin_theta = {rnd_theta[31:ANG_SHIFT], {ANG_SHIFT{1'b0}}};

    logic signed [31:0] cp;
    logic signed [31:0] sp;
    logic signed [31:0] ct;
    logic signed [31:0] st;

    smvg_cordic u_cor_phi   (.clk(clk), .en(adv), .ang(cin_phi),   .cos_q(cp), .sin_q(sp));
    smvg_cordic u_cor_theta (.clk(clk), .en(adv), .ang(cin_theta), .cos_q(ct), .sin_q(st));

    side2_t side_c_reg [COR_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_c_reg[0] <= sa_reg;
            for (int k = 1; k < COR_LAT; k++)
                side_c_reg[k] <= side_c_reg[k-1];
        end
    end

    // M1: direction products
    logic signed [16:0] rad_s;
    logic signed [63:0] t1_reg;
    logic signed [63:0] t2_reg;
    logic signed [48:0] pyp_reg;
    side2_t             s1_reg;

    assign rad_s = $signed({1'b0, cfg.radius});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg  <= cp * st;
            t2_reg  <= sp * st;
            pyp_reg <= rad_s * ct;
            s1_reg  <= side_c_reg[COR_LAT-1];
        end
    end

    // M2: round to Q2.30, finish y
    logic signed [63:0] r1;
    logic signed [63:0] r2;
    logic signed [48:0] ry;
    logic signed [33:0] tx_reg;
    logic signed [33:0] tz_reg;
    logic signed [16:0] py2_reg;
    side2_t             s2_reg;

    assign r1 = t1_reg + 64'sd536870912;
    assign r2 = t2_reg + 64'sd536870912;
    assign ry = pyp_reg + 49'sd536870912;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx_reg  <= r1[63:30];
            tz_reg  <= r2[63:30];
            py2_reg <= sat_pos({{3{ry[48]}}, ry[48:30]});
            s2_reg  <= s1_reg;
        end
    end

    // M3: scale by radius
    logic signed [50:0] pxp_reg;
    logic signed [50:0] pzp_reg;
    logic signed [16:0] py3_reg;
    side2_t             s3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxp_reg <= rad_s * tx_reg;
            pzp_reg <= rad_s * tz_reg;
            py3_reg <= py2_reg;
            s3_reg  <= s2_reg;
        end
    end

    // M4: round, negate x, saturate, form indices
    logic signed [50:0]      rxs;
    logic signed [50:0]      rzs;
    logic signed [21:0]      nx;
    logic [8:0]              stride;
    logic [16:0]             ib_full;
    logic [15:0]             ib;
    qitem_t                  item_reg;

    assign rxs     = pxp_reg + 51'sd536870912;
    assign rzs     = pzp_reg + 51'sd536870912;
    assign nx      = -$signed({rxs[50], rxs[50:30]});
    assign stride  = {1'b0, s3_reg.side.w} + 9'd1;
    assign ib_full = {9'b0, s3_reg.side.row} * {8'b0, stride} + {9'b0, s3_reg.side.col};
    assign ib      = ib_full[15:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg.outside <= s3_reg.side.outside;
            item_reg.tri_a   <= s3_reg.side.tri_a;
            item_reg.tri_b   <= s3_reg.side.tri_b;
            item_reg.px      <= sat_pos(nx);
            item_reg.py      <= py3_reg;
            item_reg.pz      <= sat_pos({rzs[50], rzs[50:30]});
            item_reg.tu      <= s3_reg.tu;
            item_reg.tv      <= s3_reg.tv;
            item_reg.ib      <= ib;
            item_reg.ia      <= ib + 16'd1;
            item_reg.ic      <= ib + {7'b0, stride};
            item_reg.id      <= ib + {7'b0, stride} + 16'd1;
        end
    end

    assign q_item = item_reg;

endmodule

// ----- rtl/smvg_back.sv -----
// Back end: item queue and expansion of each item into its vertex and triangles, or an error result.
module smvg_back
    import smvg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qitem_t     q_item,
    input  logic       q_push,
    output logic       q_full,
    smvg_res_if.source rsp
);

    localparam logic [1:0] PH_VERT  = 2'd0;
    localparam logic [1:0] PH_TRI_A = 2'd1;
    localparam logic [1:0] PH_TRI_B = 2'd2;

    qitem_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg;
    logic [Q_AW-1:0] rp_reg;
    logic [Q_AW:0]   cnt_reg;
    logic [1:0]      phase_reg;
    logic            out_vld_reg;
    res_t            out_reg;

    qitem_t     head;
    logic       has;
    logic       ld;
    logic       emit;
    logic       pop;
    logic       more;
    logic [1:0] ph_next;
    res_t       res;

    assign head   = mem_reg[rp_reg];
    assign has    = (cnt_reg != '0);
    assign q_full = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign ld     = !out_vld_reg || rsp.ready;
    assign emit   = ld && has;
    assign pop    = emit && !more;

    // Result for the current phase of the head item
    always_comb
    begin
        res     = '0;
        more    = 1'b0;
        ph_next = PH_VERT;
        case (phase_reg)
            PH_VERT:
            begin
                if (head.outside)
                begin
                    res.kind = KIND_ERROR;
                end
                else
                begin
                    res.kind    = KIND_VERTEX;
                    res.pos_x   = head.px;
                    res.pos_y   = head.py;
                    res.pos_z   = head.pz;
                    res.tex_u   = head.tu;
                    res.tex_v   = head.tv;
                    res.index_a = head.ib;
                end
                more    = head.tri_a || head.tri_b;
                ph_next = head.tri_a ? PH_TRI_A : PH_TRI_B;
            end
            PH_TRI_A:
            begin
                res.kind    = KIND_TRI;
                res.index_a = head.ia;
                res.index_b = head.ib;
                res.index_c = head.id;
                more        = head.tri_b;
                ph_next     = PH_TRI_B;
            end
            PH_TRI_B:
            begin
                res.kind    = KIND_TRI;
                res.index_a = head.ib;
                res.index_b = head.ic;
                res.index_c = head.id;
            end
            default:
            begin
                res.kind = KIND_ERROR;
            end
        endcase
        res.last = !more;
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (q_push)
            mem_reg[wp_reg] <= q_item;
    end

    // Queue pointers, phase and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
            phase_reg   <= PH_VERT;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (q_push)
                wp_reg <= wp_reg + Q_AW'(1);
            if (pop)
                rp_reg <= rp_reg + Q_AW'(1);
            cnt_reg <= cnt_reg + (Q_AW+1)'(q_push) - (Q_AW+1)'(pop);
            if (emit)
                phase_reg <= more ? ph_next : PH_VERT;
            if (ld)
                out_vld_reg <= has;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= res;
    end

    assign rsp.valid   = out_vld_reg;
    assign rsp.kind    = out_reg.kind;
    assign rsp.pos_x   = out_reg.pos_x;
    assign rsp.pos_y   = out_reg.pos_y;
    assign rsp.pos_z   = out_reg.pos_z;
    assign rsp.tex_u   = out_reg.tex_u;
    assign rsp.tex_v   = out_reg.tex_v;
    assign rsp.index_a = out_reg.index_a;
    assign rsp.index_b = out_reg.index_b;
    assign rsp.index_c = out_reg.index_c;
    assign rsp.last    = out_reg.last;

endmodule

// ----- rtl/sphere_mesh_vertex_generator_unit.sv -----
// UV sphere vertex generator: accepts one grid point (row, col) per cycle on req
// and returns on rsp the vertex at that point (Q8.8 position, Q1.14 texture
// coordinates) followed by up to two triangles of the cell whose corner it is,
// or a single error result for a point outside the grid; the last result of each
// request carries last. A new request is taken every cycle while the result side
// keeps up; results leave at one per cycle while rsp is ready, so a request with k
// results takes k output transfers. A request passes through the 41-stage long
// divider that forms the angles, the 24-step pipelined CORDIC and four multiply
// and round stages. A four-entry queue separates the arithmetic pipeline from the
// result sequencer. Registers are written on cfg (always ready) and should change
// only while no request is in flight.
module sphere_mesh_vertex_generator_unit
    import smvg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    smvg_req_if.sink   req,
    smvg_res_if.source rsp,
    smvg_cfg_if.sink   cfg
);

    cfg_t   cfg_reg;
    qitem_t q_item;
    logic   q_push;
    logic   q_full;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius       <= 16'd256;
            cfg_reg.seg_around   <= SEGMENT_BITS'(32);
            cfg_reg.seg_rings    <= SEGMENT_BITS'(16);
            cfg_reg.phi_start    <= 16'd0;
            cfg_reg.phi_length   <= 17'd65536;
            cfg_reg.theta_start  <= 16'd0;
            cfg_reg.theta_length <= 16'd32768;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_RADIUS:       cfg_reg.radius       <= cfg.data[15:0];
                REG_WIDTH_SEGS:   cfg_reg.seg_around   <= cfg.data[SEGMENT_BITS-1:0];
                REG_HEIGHT_SEGS:  cfg_reg.seg_rings    <= cfg.data[SEGMENT_BITS-1:0];
                REG_PHI_START:    cfg_reg.phi_start    <= cfg.data[15:0];
                REG_PHI_LENGTH:   cfg_reg.phi_length   <= cfg.data;
                REG_THETA_START:  cfg_reg.theta_start  <= cfg.data[15:0];
                REG_THETA_LENGTH: cfg_reg.theta_length <= cfg.data[15:0];
                default:          ;
            endcase
        end
    end

    smvg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cfg    (cfg_reg),
        .q_item (q_item),
        .q_push (q_push),
        .q_full (q_full)
    );

    smvg_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_item (q_item),
        .q_push (q_push),
        .q_full (q_full),
        .rsp    (rsp)
    );

endmodule

// ----- tb/sv/sphere_mesh_vertex_generator_unit_tb.sv -----
// Self-checking testbench for the UV sphere vertex and triangle generator.
module sphere_mesh_vertex_generator_unit_tb
    import smvg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Sphere mesh predictor and the results it still expects
    class sphere_mesh_board;
        cfg_t regs;
        res_t pending[$];
        int   errors;

        function new();
            regs.radius       = 16'd256;
            regs.seg_around   = 8'd32;
            regs.seg_rings    = 8'd16;
            regs.phi_start    = 16'd0;
            regs.phi_length   = 17'd65536;
            regs.theta_start  = 16'd0;
            regs.theta_length = 16'd32768;
            errors = 0;
        endfunction

        function void apply_reg(logic [2:0] idx, logic [16:0] val);
            case (idx)
                REG_RADIUS:       regs.radius       = val[15:0];
                REG_WIDTH_SEGS:   regs.seg_around   = val[7:0];
                REG_HEIGHT_SEGS:  regs.seg_rings    = val[7:0];
                REG_PHI_START:    regs.phi_start    = val[15:0];
                REG_PHI_LENGTH:   regs.phi_length   = val;
                REG_THETA_START:  regs.theta_start  = val[15:0];
                REG_THETA_LENGTH: regs.theta_length = val[15:0];
                default: ;
            endcase
        endfunction

        // Angle in 2^-32 turn, rounded to a 16-bit turn fraction
        function logic [31:0] round_angle(longint a);
            logic [31:0] low;
            longint      q;
            low = a[31:0];
            q = (longint'(low) + (64'sd1 << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
            q = q & ((64'sd1 << ANGLE_BITS) - 1);
            return q[31:0] << ANG_SHIFT;
        endfunction

        // Q2.30 cosine and sine by rotation
        function void sin_cos(input logic [31:0] ang, output longint c, output longint s);
            longint      x, y, z, dx, dy;
            logic [31:0] a;
            bit          flip;
            a = ang;
            flip = 0;
            x = 652032874;
            y = 0;
            if (a >= 32'h4000_0000 && a < 32'hC000_0000)
            begin
                a = a - 32'h8000_0000;
                flip = 1;
            end
            z = longint'($signed(a));
            for (int i = 0; i < COR_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx; y = y + dy; z = z - longint'(ATAN_TURN[i]);
                end
                else
                begin
                    x = x + dx; y = y - dy; z = z + longint'(ATAN_TURN[i]);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint clip_pos(longint v);
            if (v > 65535) return 65535;
            if (v < -65535) return -65535;
            return v;
        endfunction

        // Expected results of one accepted grid point
        function void note_request(logic [7:0] row, logic [7:0] col);
            int     w, h, num, tu, tv, ib, stride, n;
            longint cp, sp, ct, st, t, px, py, pz;
            bit     to_bottom;
            res_t   r[3];
            w = regs.seg_around;
            h = regs.seg_rings;
            if (w < 3) w = 3;
            if (h < 2) h = 2;
            if (row > h || col > w)
            begin
                r[0] = '0;
                r[0].kind = KIND_ERROR;
                r[0].last = 1'b1;
                pending = {pending, r[0]};
                return;
            end
            to_bottom = (int'(regs.theta_start) + int'(regs.theta_length)) >= 32768;
            sin_cos(round_angle((longint'(regs.phi_start) << 16) +
                    ((longint'(col) * longint'(regs.phi_length)) << 16) / w), cp, sp);
            sin_cos(round_angle((longint'(regs.theta_start) << 16) +
                    ((longint'(row) * longint'(regs.theta_length)) << 16) / h), ct, st);
            py = clip_pos((longint'(regs.radius) * ct + (64'sd1 << 29)) >>> 30);
            t  = (cp * st + (64'sd1 << 29)) >>> 30;
            px = clip_pos(-((longint'(regs.radius) * t + (64'sd1 << 29)) >>> 30));
            t  = (sp * st + (64'sd1 << 29)) >>> 30;
            pz = clip_pos((longint'(regs.radius) * t + (64'sd1 << 29)) >>> 30);
            // pole offset on u
            num = 2 * int'(col) * 8192;
            if (row == 0 && regs.theta_start == 0)
                num = num + 8192;
            else if (row == h && to_bottom)
                num = num - 8192;
            if (num >= 0)
                tu = (num + w / 2) / w;
            else
                tu = -((-num + w / 2) / w);
            tv = ((h - int'(row)) * 16384 + h / 2) / h;
            stride = w + 1;
            ib = int'(row) * stride + int'(col);
            r[0] = '0;
            r[0].kind    = KIND_VERTEX;
            r[0].pos_x   = px[16:0];
            r[0].pos_y   = py[16:0];
            r[0].pos_z   = pz[16:0];
            r[0].tex_u   = tu[15:0];
            r[0].tex_v   = tv[14:0];
            r[0].index_a = ib[15:0];
            n = 1;
            if (row < h && col < w)
            begin
                if (row != 0 || regs.theta_start > 0)
                begin
                    r[n] = '0;
                    r[n].kind    = KIND_TRI;
                    r[n].index_a = 16'(ib + 1);
                    r[n].index_b = 16'(ib);
                    r[n].index_c = 16'(ib + stride + 1);
                    n++;
                end
                if (row != h - 1 || !to_bottom)
                begin
                    r[n] = '0;
                    r[n].kind    = KIND_TRI;
                    r[n].index_a = 16'(ib);
                    r[n].index_b = 16'(ib + stride);
                    r[n].index_c = 16'(ib + stride + 1);
                    n++;
                end
            end
            r[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                pending = {pending, r[i]};
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind)
                begin $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind); errors++; end
            if (got.pos_x !== exp_r.pos_x)
                begin $display("%0t: pos_x exp %h got %h", $time, exp_r.pos_x, got.pos_x); errors++; end
            if (got.pos_y !== exp_r.pos_y)
                begin $display("%0t: pos_y exp %h got %h", $time, exp_r.pos_y, got.pos_y); errors++; end
            if (got.pos_z !== exp_r.pos_z)
                begin $display("%0t: pos_z exp %h got %h", $time, exp_r.pos_z, got.pos_z); errors++; end
            if (got.tex_u !== exp_r.tex_u)
                begin $display("%0t: tex_u exp %h got %h", $time, exp_r.tex_u, got.tex_u); errors++; end
            if (got.tex_v !== exp_r.tex_v)
                begin $display("%0t: tex_v exp %h got %h", $time, exp_r.tex_v, got.tex_v); errors++; end
            if (got.index_a !== exp_r.index_a)
                begin $display("%0t: index_a exp %0d got %0d", $time, exp_r.index_a, got.index_a); errors++; end
            if (got.index_b !== exp_r.index_b)
                begin $display("%0t: index_b exp %0d got %0d", $time, exp_r.index_b, got.index_b); errors++; end
            if (got.index_c !== exp_r.index_c)
                begin $display("%0t: index_c exp %0d got %0d", $time, exp_r.index_c, got.index_c); errors++; end
            if (got.last !== exp_r.last)
                begin $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last); errors++; end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   stall_left;
    sphere_mesh_board board;

    smvg_req_if req_ch();
    smvg_res_if rsp_ch();
    smvg_cfg_if cfg_ch();

    sphere_mesh_vertex_generator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Result side: random stall bursts on ready
    always @(negedge clk)
    begin
        if (calm)
            rsp_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.kind    = rsp_ch.kind;
            got.pos_x   = rsp_ch.pos_x;
            got.pos_y   = rsp_ch.pos_y;
            got.pos_z   = rsp_ch.pos_z;
            got.tex_u   = rsp_ch.tex_u;
            got.tex_v   = rsp_ch.tex_v;
            got.index_a = rsp_ch.index_a;
            got.index_b = rsp_ch.index_b;
            got.index_c = rsp_ch.index_c;
            got.last    = rsp_ch.last;
            board.check_result(got);
        end
    end

    // One register write; valid is lowered by the caller
    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        board.apply_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic program_sphere(input logic [15:0] rad, input logic [7:0] ws,
                                  input logic [7:0] hs, input logic [15:0] ps,
                                  input logic [16:0] pl, input logic [15:0] ts,
                                  input logic [15:0] tl);
        write_reg(REG_RADIUS, 17'(rad));
        write_reg(REG_WIDTH_SEGS, 17'(ws));
        write_reg(REG_HEIGHT_SEGS, 17'(hs));
        write_reg(REG_PHI_START, 17'(ps));
        write_reg(REG_PHI_LENGTH, pl);
        write_reg(REG_THETA_START, 17'(ts));
        write_reg(REG_THETA_LENGTH, 17'(tl));
        cfg_ch.valid <= 1'b0;
    endtask

    // One grid point transaction, with an occasional gap before it
    task automatic send_point(input logic [7:0] r, input logic [7:0] c);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.row   <= r;
        req_ch.col   <= c;
        do @(posedge clk); while (!req_ch.ready);
        board.note_request(r, c);
        @(negedge clk);
    endtask

    // Let every expected result arrive, then let the pipeline settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (90) @(negedge clk);
    endtask

    task automatic random_points(input int count);
        int w, h;
        w = (board.regs.seg_around < 3) ? 3 : board.regs.seg_around;
        h = (board.regs.seg_rings < 2) ? 2 : board.regs.seg_rings;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_point(8'($urandom), 8'($urandom));
            else
                send_point(8'($urandom_range(0, h + 1)), 8'($urandom_range(0, w + 1)));
        end
    endtask

    initial
    begin
        board = new();
        calm = 0;
        stall_left = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.row = '0;
        req_ch.col = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_RADIUS;
        cfg_ch.data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Reset settings: poles, seam, corners and outside points
        send_point(8'd0, 8'd0);
        send_point(8'd0, 8'd31);
        send_point(8'd15, 8'd31);
        send_point(8'd16, 8'd0);
        send_point(8'd16, 8'd32);
        send_point(8'd8, 8'd16);
        send_point(8'd17, 8'd0);
        send_point(8'd0, 8'd33);
        send_point(8'd255, 8'd255);
        drain();

        // Clamped minimum grid, largest radius and sweep
        program_sphere(16'hFFFF, 8'd0, 8'd0, 16'hFFFF, 17'd65536, 16'd0, 16'd32768);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 5; c++)
                send_point(8'(r), 8'(c));
        drain();

        // Largest grid, zero radius and sweep, start at the bottom pole
        program_sphere(16'd0, 8'd255, 8'd255, 16'd0, 17'd0, 16'd32768, 16'd0);
        send_point(8'd255, 8'd255);
        send_point(8'd254, 8'd254);
        send_point(8'd0, 8'd0);
        send_point(8'd255, 8'd0);
        send_point(8'd128, 8'd200);
        drain();

        // Theta past pi wraps around the turn
        program_sphere(16'd300, 8'd5, 8'd4, 16'd12345, 17'd40000, 16'd30000, 16'd32768);
        random_points(12);
        drain();

        // Random settings; full-width grid once so every index bit toggles
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                calm = 1;
            if (ph == 2)
                program_sphere(16'($urandom), 8'd255, 8'd255, 16'($urandom),
                               17'($urandom_range(0, 65536)), 16'($urandom_range(0, 32768)),
                               16'($urandom_range(0, 32768)));
            else
                program_sphere(($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                               8'($urandom_range(0, 12)), 8'($urandom_range(0, 10)),
                               16'($urandom),
                               ($urandom_range(0, 3) == 0) ? 17'd65536
                                                           : 17'($urandom_range(0, 65536)),
                               ($urandom_range(0, 2) == 0) ? 16'd0
                                                           : 16'($urandom_range(0, 32768)),
                               16'($urandom_range(0, 32768)));
            random_points(22);
            if (ph == 4)
            begin
                // sender holds off until everything is out
                req_ch.valid <= 1'b0;
                while (board.pending.size() != 0) @(negedge clk);
            end
            random_points(22);
            drain();
        end

        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/smvg_pkg.sv
rtl/smvg_if.sv
rtl/smvg_div.sv
rtl/smvg_cordic.sv
rtl/smvg_front.sv
rtl/smvg_back.sv
rtl/sphere_mesh_vertex_generator_unit.sv
tb/sv/sphere_mesh_vertex_generator_unit_tb.sv
